// ===== src/arc_band_run_rasterizer_defines.svh =====
// ----------------------------------------------------------------------------
// arc band run rasterizer assertion macros
// shared concurrent check forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ARC_BAND_RUN_RASTERIZER_DEFINES_SVH
`define ARC_BAND_RUN_RASTERIZER_DEFINES_SVH

// same-cycle implication
`define ABRR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("abrr check failed");

// next-cycle implication
`define ABRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("abrr check failed");

`endif

// ===== src/abrr_pkg.sv =====
// ----------------------------------------------------------------------------
// abrr package
// widths, register map, sine table, controller states and command structs
// ----------------------------------------------------------------------------
package abrr_pkg;

  localparam int MAX_RADIUS_DEF = 512;
  localparam int SINE_DEPTH     = 91;

  localparam int OFF_W   = 11;
  localparam int CTR_W   = 12;
  localparam int RAD_W   = 10;
  localparam int ANG_W   = 11;
  localparam int COLOR_W = 16;
  localparam int RUN_W   = 11;
  localparam int SINE_W  = 15;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam int SEARCH_LIMIT = 45;
  localparam int QUARTER      = 90;
  localparam int HALF         = 180;
  localparam int FULL         = 360;

  localparam logic [SINE_W-1:0] SINE_Q14 [SINE_DEPTH] = '{
    15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
    15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
    15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
    15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
    15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
    15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982,
    15'd12176, 15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085,
    15'd13255, 15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
    15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849,
    15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491,
    15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964,
    15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
    15'd16384
  };

  typedef enum logic [2:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_INNER_RADIUS,
    REG_OUTER_RADIUS,
    REG_START_ANGLE,
    REG_END_ANGLE,
    REG_BAND_COLOR
  } reg_idx_t;

  typedef struct packed {
    logic [CTR_W-1:0]   center_x;
    logic [CTR_W-1:0]   center_y;
    logic [RAD_W-1:0]   inner_radius;
    logic [RAD_W-1:0]   outer_radius;
    logic [ANG_W-1:0]   start_angle;
    logic [ANG_W-1:0]   end_angle;
    logic [COLOR_W-1:0] band_color;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_RO,
    ST_RI,
    ST_PRIME,
    ST_SEARCH,
    ST_ANGLE,
    ST_REDUCE,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    DIST_NONE,
    DIST_SQX,
    DIST_SQY,
    DIST_RO,
    DIST_RI
  } dist_op_t;

  typedef struct packed {
    logic     load_in;
    dist_op_t dist_op;
    logic     search_prime;
    logic     search_step;
    logic     angle_load;
    logic     reduce_step;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic search_go;
    logic reduce_done;
    logic out_free;
  } stat_t;

endpackage

// ===== src/abrr_pix_if.sv =====
// ----------------------------------------------------------------------------
// abrr pixel channel
// valid/ready channel carrying one pixel offset item
// ----------------------------------------------------------------------------
interface abrr_pix_if;
  logic                            valid;
  logic                            ready;
  logic signed [abrr_pkg::OFF_W-1:0] offset_x;
  logic signed [abrr_pkg::OFF_W-1:0] offset_y;

  modport source (output valid, output offset_x, output offset_y, input ready);
  modport sink (input valid, input offset_x, input offset_y, output ready);
endinterface

// ===== src/abrr_run_if.sv =====
// ----------------------------------------------------------------------------
// abrr run channel
// valid/ready channel carrying one clipped run item
// ----------------------------------------------------------------------------
interface abrr_run_if;
  logic                          valid;
  logic                          ready;
  logic [abrr_pkg::RUN_W-1:0]    run_x;
  logic [abrr_pkg::RUN_W-1:0]    run_y;
  logic [abrr_pkg::RUN_W-1:0]    run_width;
  logic [abrr_pkg::COLOR_W-1:0]  run_color;

  modport source (output valid, output run_x, output run_y, output run_width,
                  output run_color, input ready);
  modport sink (input valid, input run_x, input run_y, input run_width,
                input run_color, output ready);
endinterface

// ===== src/abrr_ctrl.sv =====
// ----------------------------------------------------------------------------
// abrr controller
// sequences distance squares, angle search, arc reduction and run update
// ----------------------------------------------------------------------------
module abrr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            pix_valid,
  output logic            pix_ready,
  input  abrr_pkg::stat_t stat,
  output abrr_pkg::cmd_t  cmd
);
  import abrr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.dist_op = DIST_NONE;
    pix_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        pix_ready   = 1'b1;
        cmd.load_in = pix_valid;
        if (pix_valid) begin
          state_next = ST_SQX;
        end
      end
      ST_SQX: begin
        cmd.dist_op = DIST_SQX;
        state_next  = ST_SQY;
      end
      ST_SQY: begin
        cmd.dist_op = DIST_SQY;
        state_next  = ST_RO;
      end
      ST_RO: begin
        cmd.dist_op = DIST_RO;
        state_next  = ST_RI;
      end
      ST_RI: begin
        cmd.dist_op = DIST_RI;
        state_next  = ST_PRIME;
      end
      ST_PRIME: begin
        cmd.search_prime = 1'b1;
        state_next       = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (stat.search_go) begin
          cmd.search_step = 1'b1;
        end else begin
          state_next = ST_ANGLE;
        end
      end
      ST_ANGLE: begin
        cmd.angle_load = 1'b1;
        state_next     = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (stat.reduce_done) begin
          state_next = ST_FINISH;
        end else begin
          cmd.reduce_step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end
endmodule

// ===== src/abrr_dp.sv =====
// ----------------------------------------------------------------------------
// abrr datapath
// squares, sine search multipliers, angle fold, arc test, run state, output
// ----------------------------------------------------------------------------
module abrr_dp #(
  parameter int MAX_RADIUS = abrr_pkg::MAX_RADIUS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  abrr_pkg::cfg_t                      cfg,
  input  abrr_pkg::cmd_t                      cmd,
  output abrr_pkg::stat_t                     stat,
  input  logic signed [abrr_pkg::OFF_W-1:0]   offset_x,
  input  logic signed [abrr_pkg::OFF_W-1:0]   offset_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [abrr_pkg::RUN_W-1:0]          run_x,
  output logic [abrr_pkg::RUN_W-1:0]          run_y,
  output logic [abrr_pkg::RUN_W-1:0]          run_width,
  output logic [abrr_pkg::COLOR_W-1:0]        run_color
);
  import abrr_pkg::*;

  localparam int SQ_W   = 2 * OFF_W;
  localparam int PROD_W = OFF_W + SINE_W;
  localparam int CNT_W  = 6;
  localparam int IDX_W  = 7;
  localparam int DEG_W  = 9;
  localparam int ARC_W  = 12;

  // item and working registers
  logic [OFF_W-1:0]  dx;
  logic [OFF_W-1:0]  dy;
  logic [OFF_W-1:0]  ax;
  logic [OFF_W-1:0]  ay;
  logic [SQ_W-1:0]   d2;
  logic [SQ_W-1:0]   ro2;
  logic [SQ_W-1:0]   ri2;
  logic [PROD_W-1:0] pa;
  logic [PROD_W-1:0] pb;
  logic [CNT_W-1:0]  a_cnt;
  logic [ARC_W-1:0]  arc_d;

  // run state
  logic             in_run;
  logic [OFF_W-1:0] run_start_offset;

  logic [RAD_W-1:0]  ro_sat;
  logic [RAD_W-1:0]  ri_sat;
  logic [OFF_W-1:0]  big;
  logic [OFF_W-1:0]  small_side;
  logic [OFF_W-1:0]  sq_op;
  logic [SQ_W-1:0]   sq_prod;
  logic [CNT_W-1:0]  s_idx;
  logic [IDX_W-1:0]  idx_lo;
  logic [IDX_W-1:0]  idx_hi;
  logic [PROD_W-1:0] pa_next;
  logic [PROD_W-1:0] pb_next;
  logic [IDX_W-1:0]  a_fold;
  logic [DEG_W-1:0]  ang;
  logic              dy_le0;
  logic [ARC_W-1:0]  span;
  logic              in_band;
  logic [12:0]       x_raw;
  logic [12:0]       y_raw;
  logic [11:0]       w_raw;
  logic [13:0]       w_clip;
  logic [12:0]       x_clip;
  logic              emit;

  assign ro_sat = (int'(cfg.outer_radius) > MAX_RADIUS) ?
                  RAD_W'(MAX_RADIUS) : cfg.outer_radius;
  assign ri_sat = (int'(cfg.inner_radius) > MAX_RADIUS) ?
                  RAD_W'(MAX_RADIUS) : cfg.inner_radius;

  assign big        = (ax >= ay) ? ax : ay;
  assign small_side = (ax >= ay) ? ay : ax;

  // squares share one multiplier
  always_comb begin
    case (cmd.dist_op)
      DIST_SQX: sq_op = ax;
      DIST_SQY: sq_op = ay;
      DIST_RO:  sq_op = {1'b0, ro_sat};
      DIST_RI:  sq_op = {1'b0, ri_sat};
      default:  sq_op = '0;
    endcase
  end

  assign sq_prod = {{OFF_W{1'b0}}, sq_op} * {{OFF_W{1'b0}}, sq_op};

  // products for the next step are formed while the current ones compare
  assign s_idx   = cmd.search_prime ? '0 : CNT_W'(a_cnt + 1'b1);
  assign idx_lo  = {1'b0, s_idx};
  assign idx_hi  = IDX_W'(QUARTER) - idx_lo;
  assign pa_next = {{SINE_W{1'b0}}, small_side} * {{OFF_W{1'b0}}, SINE_Q14[idx_hi]};
  assign pb_next = {{SINE_W{1'b0}}, big} * {{OFF_W{1'b0}}, SINE_Q14[idx_lo]};

  assign stat.search_go = (a_cnt < CNT_W'(SEARCH_LIMIT)) && (pa > pb);

  // octant fold back to a full-circle angle
  assign a_fold = (ax < ay) ? IDX_W'(QUARTER) - {1'b0, a_cnt} : {1'b0, a_cnt};
  assign dy_le0 = dy[OFF_W-1] || (dy == '0);

  always_comb begin
    if (!dx[OFF_W-1]) begin
      if (dy_le0 || (a_fold == '0)) begin
        ang = {2'b00, a_fold};
      end else begin
        ang = DEG_W'(FULL) - {2'b00, a_fold};
      end
    end else begin
      if (dy_le0) begin
        ang = DEG_W'(HALF) - {2'b00, a_fold};
      end else begin
        ang = DEG_W'(HALF) + {2'b00, a_fold};
      end
    end
  end

  assign stat.reduce_done = !arc_d[ARC_W-1] && ($signed(arc_d) < $signed(ARC_W'(FULL)));

  assign span = {cfg.start_angle[ANG_W-1], cfg.start_angle} -
                {cfg.end_angle[ANG_W-1], cfg.end_angle};

  assign in_band = ($signed({dx[OFF_W-1], dx}) <= $signed({2'b00, ro_sat})) &&
                   (d2 <= ro2) && (d2 >= ri2) && ($signed(arc_d) <= $signed(span));

  // run close geometry with left clip
  assign x_raw  = {cfg.center_x[CTR_W-1], cfg.center_x} +
                  {{2{run_start_offset[OFF_W-1]}}, run_start_offset};
  assign y_raw  = {cfg.center_y[CTR_W-1], cfg.center_y} + {{2{dy[OFF_W-1]}}, dy};
  assign w_raw  = {dx[OFF_W-1], dx} - {run_start_offset[OFF_W-1], run_start_offset};
  assign w_clip = x_raw[12] ? {{2{w_raw[11]}}, w_raw} + {x_raw[12], x_raw} :
                              {{2{w_raw[11]}}, w_raw};
  assign x_clip = x_raw[12] ? '0 : x_raw;
  assign emit   = in_run && !in_band && !y_raw[12] && !w_clip[13] && (w_clip != '0);

  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dx <= offset_x;
      dy <= offset_y;
      ax <= offset_x[OFF_W-1] ? OFF_W'(-offset_x) : offset_x;
      ay <= offset_y[OFF_W-1] ? OFF_W'(-offset_y) : offset_y;
    end
    case (cmd.dist_op)
      DIST_SQX: d2  <= sq_prod;
      DIST_SQY: d2  <= d2 + sq_prod;
      DIST_RO:  ro2 <= sq_prod;
      DIST_RI:  ri2 <= sq_prod;
      default: begin
      end
    endcase
    if (cmd.search_prime || cmd.search_step) begin
      pa <= pa_next;
      pb <= pb_next;
    end
    if (cmd.search_prime) begin
      a_cnt <= '0;
    end else if (cmd.search_step) begin
      a_cnt <= s_idx;
    end
    if (cmd.angle_load) begin
      arc_d <= {cfg.start_angle[ANG_W-1], cfg.start_angle} - {3'b000, ang};
    end else if (cmd.reduce_step) begin
      if (arc_d[ARC_W-1]) begin
        arc_d <= arc_d + ARC_W'(FULL);
      end else begin
        arc_d <= arc_d - ARC_W'(FULL);
      end
    end
    if (cmd.finish && emit) begin
      run_x     <= x_clip[RUN_W-1:0];
      run_y     <= y_raw[RUN_W-1:0];
      run_width <= w_clip[RUN_W-1:0];
      run_color <= cfg.band_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_run           <= 1'b0;
      run_start_offset <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cmd.finish) begin
        if (in_band && !in_run) begin
          in_run           <= 1'b1;
          run_start_offset <= dx;
        end else if (!in_band && in_run) begin
          in_run <= 1'b0;
        end
      end
      if (cmd.finish && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

// ===== src/arc_band_run_rasterizer.sv =====
// ----------------------------------------------------------------------------
// arc band run rasterizer
// classifies pixel offsets against an annular sector and emits clipped runs
//
//   channel  dir  handshake        payload
//   pix      in   valid / ready    offset_x, offset_y
//   run      out  valid / ready    run_x, run_y, run_width, run_color
//   apb      in   psel / penable   paddr, pwdata, prdata
//
// a new pixel is taken only once the last one is finished; the angle
// search steps one sine table entry per cycle through up to 45 entries, and
// the arc reduction takes up to four add or subtract steps
// a finished run waits in the output register while the next pixel is taken;
// a pixel that finishes while that register is still held waits until it drains
// rst is synchronous and clears the controller, the run state and run valid
// ----------------------------------------------------------------------------
module arc_band_run_rasterizer #(
  parameter int MAX_RADIUS = abrr_pkg::MAX_RADIUS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  abrr_pix_if.sink                      pix,
  abrr_run_if.source                    run,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [abrr_pkg::ADDR_W-1:0]   paddr,
  input  logic [abrr_pkg::DATA_W-1:0]   pwdata,
  output logic [abrr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import abrr_pkg::*;
  `include "arc_band_run_rasterizer_defines.svh"

  cfg_t     cfg;
  cmd_t     cmd;
  stat_t    stat;
  reg_idx_t reg_sel;
  logic     cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_sel   = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_CENTER_X:     cfg.center_x     <= pwdata[CTR_W-1:0];
        REG_CENTER_Y:     cfg.center_y     <= pwdata[CTR_W-1:0];
        REG_INNER_RADIUS: cfg.inner_radius <= pwdata[RAD_W-1:0];
        REG_OUTER_RADIUS: cfg.outer_radius <= pwdata[RAD_W-1:0];
        REG_START_ANGLE:  cfg.start_angle  <= pwdata[ANG_W-1:0];
        REG_END_ANGLE:    cfg.end_angle    <= pwdata[ANG_W-1:0];
        REG_BAND_COLOR:   cfg.band_color   <= pwdata[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CENTER_X:     prdata = DATA_W'(cfg.center_x);
      REG_CENTER_Y:     prdata = DATA_W'(cfg.center_y);
      REG_INNER_RADIUS: prdata = DATA_W'(cfg.inner_radius);
      REG_OUTER_RADIUS: prdata = DATA_W'(cfg.outer_radius);
      REG_START_ANGLE:  prdata = DATA_W'(cfg.start_angle);
      REG_END_ANGLE:    prdata = DATA_W'(cfg.end_angle);
      REG_BAND_COLOR:   prdata = DATA_W'(cfg.band_color);
      default:          prdata = '0;
    endcase
  end

  abrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix.valid),
    .pix_ready (pix.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  abrr_dp #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .offset_x  (pix.offset_x),
    .offset_y  (pix.offset_y),
    .out_valid (run.valid),
    .out_ready (run.ready),
    .run_x     (run.run_x),
    .run_y     (run.run_y),
    .run_width (run.run_width),
    .run_color (run.run_color)
  );

  `ABRR_ASSERT_NEXT(a_busy_after_accept, pix.valid && pix.ready, !pix.ready)
  `ABRR_ASSERT_NOW(a_run_from_busy, $rose(run.valid), !$past(pix.ready))
  `ABRR_ASSERT_NOW(a_run_width_set, run.valid, run.run_width != '0)
endmodule
